// ----- hdl/table_linear_interpolator_assert.svh -----
// Assertion macros for the table interpolator
`ifndef TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTH
`define TLI_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define TLI_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define TLI_ASSERT_IMP(label, clk, rst_n, a, c)
`define TLI_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- hdl/tli_pkg.sv -----
// ---------------------------------------------------------------------------
// tli_pkg
// Shared types and constants of the table interpolator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package tli_pkg;
    localparam int TableDepth = 16;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = $clog2(TableDepth + 1);
    localparam int QDepth = 2;
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;
    localparam logic [1:0] REG_ENTRIES = 2'd0;

    typedef struct packed {
        logic            mode;
        logic [3:0]      idx;
        logic [31:0]     absc;
        logic [31:0]     val;
        logic [31:0]     temp;
    } t_item;

    typedef struct packed {
        logic [31:0] rate;
        logic        below_first;
        logic        beyond_last;
        logic        clamped;
    } t_result;
endpackage

// ----- hdl/tli_front.sv -----
// ---------------------------------------------------------------------------
// tli_front
// Input stage: takes write and query beats into a short queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tli_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tli_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output tli_pkg::t_item o_item
);
    import tli_pkg::*;
    `include "table_linear_interpolator_assert.svh"

    localparam int PW = $clog2(QDepth);
    t_item            r_q [QDepth];
    logic [PW-1:0]    r_wp, r_rp;
    logic [PW:0]      r_cnt;
    logic             push, pop;

    assign o_ready = (r_cnt != (PW+1)'(QDepth));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    `TLI_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= (PW+1)'(QDepth))
    `TLI_ASSERT_NEXT(a_full_stays, i_clk, i_rst_n, !o_ready && !pop, !o_ready)
    `TLI_ASSERT_NEXT(a_cnt_push, i_clk, i_rst_n, push && !pop, r_cnt == $past(r_cnt) + 1'b1)
endmodule

// ----- hdl/tli_back.sv -----
// ---------------------------------------------------------------------------
// tli_back
// Execution: table store, breakpoint search, products, restoring divide.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tli_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [4:0]       i_entries,
    input  logic             i_valid,
    output logic             o_ready,
    input  tli_pkg::t_item   i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output tli_pkg::t_result o_res
);
    import tli_pkg::*;
    `include "table_linear_interpolator_assert.svh"

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SRCH  = 8'b00000010,
        S_PREP  = 8'b00000100,
        S_MUL1  = 8'b00001000,
        S_MUL2  = 8'b00010000,
        S_SUM   = 8'b00100000,
        S_DIV   = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    t_state          r_st;
    logic [31:0]     r_ta [TableDepth];
    logic [31:0]     r_tv [TableDepth];
    logic [31:0]     r_tq;
    logic [CntW-1:0] r_i;
    logic [31:0]     r_lt, r_ht, r_lv, r_hv;
    logic            r_rd;
    logic            r_aneg, r_dneg;
    logic [31:0]     r_amag, r_bmag, r_dmag;
    logic [63:0]     r_p1, r_p2;
    logic [64:0]     r_num;
    logic            r_nneg;
    logic [32:0]     r_rem;
    logic [6:0]      r_dc;
    logic [64:0]     r_quo;
    t_result         r_res;
    logic            r_ovalid;

    logic [IdxW-1:0] ridx;
    logic [31:0]     rd_a;
    logic [32:0]     trial;
    logic [64:0]     nsum;
    logic [IdxW-1:0] lo_idx;

    assign ridx   = r_i[IdxW-1:0];
    assign lo_idx = ridx - 1'b1;
    assign rd_a   = r_ta[ridx];
    assign o_ready = (r_st == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_res   = r_res;
    assign trial   = {r_rem[31:0], r_num[64]} - {1'b0, r_dmag};
    assign nsum    = {1'b0, r_p1} + {1'b0, r_p2};

    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && i_valid && o_ready && i_item.mode == MODE_WRITE) begin
            r_ta[i_item.idx[IdxW-1:0]] <= i_item.absc;
            r_tv[i_item.idx[IdxW-1:0]] <= i_item.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (i_valid && o_ready && i_item.mode == MODE_QUERY) begin
                        r_tq <= i_item.temp;
                        r_i  <= CntW'(1);
                        r_st <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    // one breakpoint per cycle
                    if (r_i >= CntW'(i_entries)) begin
                        r_res.rate        <= r_tv[IdxW'(i_entries - 1'b1)];
                        r_res.below_first <= 1'b0;
                        r_res.beyond_last <= 1'b1;
                        r_res.clamped     <= 1'b0;
                        r_st              <= S_OUT;
                    end else if (rd_a > r_tq) begin
                        r_lt <= r_ta[lo_idx];
                        r_ht <= rd_a;
                        r_lv <= r_tv[lo_idx];
                        r_hv <= r_tv[ridx];
                        r_rd <= (r_i == CntW'(1));
                        r_st <= S_PREP;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_PREP: begin
                    r_res.beyond_last <= 1'b0;
                    r_res.clamped     <= 1'b0;
                    r_res.below_first <= r_rd && (r_tq < r_lt);
                    r_aneg <= r_tq < r_lt;
                    r_amag <= (r_tq < r_lt) ? r_lt - r_tq : r_tq - r_lt;
                    r_bmag <= r_ht - r_tq;
                    r_dneg <= r_ht < r_lt;
                    r_dmag <= (r_ht < r_lt) ? r_lt - r_ht : r_ht - r_lt;
                    if (r_ht == r_lt) begin
                        r_res.rate <= r_lv;
                        r_st       <= S_OUT;
                    end else begin
                        r_st <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_p1 <= 64'(r_hv) * 64'(r_amag);
                    r_st <= S_MUL2;
                end
                S_MUL2: begin
                    r_p2 <= 64'(r_lv) * 64'(r_bmag);
                    r_st <= S_SUM;
                end
                S_SUM: begin
                    if (!r_aneg) begin
                        r_num <= nsum;  r_nneg <= 1'b0;
                    end else if (r_p2 >= r_p1) begin
                        r_num <= {1'b0, r_p2 - r_p1};  r_nneg <= 1'b0;
                    end else begin
                        r_num <= {1'b0, r_p1 - r_p2};  r_nneg <= 1'b1;
                    end
                    r_rem <= '0;
                    r_quo <= '0;
                    r_dc  <= 7'd65;
                    r_st  <= S_DIV;
                end
                S_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    if (r_dc == 7'd0) begin
                        if (r_quo == '0) begin
                            r_res.rate <= '0;
                        end else if (r_nneg != r_dneg) begin
                            r_res.rate <= '0;  r_res.clamped <= 1'b1;
                        end else if (r_quo[64:32] != '0) begin
                            r_res.rate <= '1;  r_res.clamped <= 1'b1;
                        end else begin
                            r_res.rate <= r_quo[31:0];
                        end
                        r_st <= S_OUT;
                    end else begin
                        if (!trial[32]) begin
                            r_rem <= trial;
                            r_quo <= {r_quo[63:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[31:0], r_num[64]};
                            r_quo <= {r_quo[63:0], 1'b0};
                        end
                        r_num <= {r_num[63:0], 1'b0};
                        r_dc  <= r_dc - 1'b1;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_st     <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `TLI_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, r_st != S_IDLE, !o_ready)
    `TLI_ASSERT_NEXT(a_out_sets_valid, i_clk, i_rst_n, r_st == S_OUT && !r_ovalid, o_valid)
    `TLI_ASSERT_IMP(a_div_nonzero, i_clk, i_rst_n, r_st == S_DIV, r_dmag != '0)
endmodule

// ----- hdl/table_linear_interpolator.sv -----
// ---------------------------------------------------------------------------
// table_linear_interpolator
// Piecewise linear interpolation over a 16-entry breakpoint table.
// ---------------------------------------------------------------------------
// channel   dir  handshake            payload
// s_axis    in   s_axis_tvalid/ready  mode, index, abscissa, value, temperature
// m_axis    out  m_axis_tvalid/ready  rate; tuser below/beyond/clamped
// apb       in   psel/penable         entries_in_use at 0x0
// A write beat waits in the input queue and is written when the back end is idle; a query
// goes through the breakpoint search, set-up, products and sum, the bit-serial divider
// and the output register (zero-width and beyond-last cases skip the arithmetic).
// Reset is synchronous, active low; the table is undefined until written.
// A two-beat input queue keeps accepting while the back end or output stalls, until full.
`timescale 1ns / 1ps
module table_linear_interpolator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] mode [4:1] entry_index [36:5] entry_abscissa [68:37] entry_value
    // [100:69] query_temperature, zero fill to 104
    input  logic [103:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] rate
    output logic [31:0] m_axis_tdata,
    // [0] below_first [1] beyond_last [2] clamped
    output logic [2:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tli_pkg::*;

    logic [4:0]  r_entries;
    t_item       in_item, q_item;
    t_result     res;
    logic        q_valid, q_ready;

    assign pready = 1'b1;
    assign prdata = (paddr[2:2] == REG_ENTRIES[0:0]) ? {27'd0, r_entries} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= 5'd1;
        end else if (psel && penable && pwrite && paddr[2:2] == REG_ENTRIES[0:0]) begin
            if (pwdata[4:0] == 5'd0)
                r_entries <= 5'd1;
            else if (pwdata[4:0] > 5'(TableDepth))
                r_entries <= 5'(TableDepth);
            else
                r_entries <= pwdata[4:0];
        end
    end

    assign in_item.mode = s_axis_tdata[0];
    assign in_item.idx  = s_axis_tdata[4:1];
    assign in_item.absc = s_axis_tdata[36:5];
    assign in_item.val  = s_axis_tdata[68:37];
    assign in_item.temp = s_axis_tdata[100:69];

    tli_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_item(in_item),
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    tli_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_entries(r_entries),
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = res.rate;
    assign m_axis_tuser = {res.clamped, res.beyond_last, res.below_first};
endmodule

// ----- tb/sv/tb_table_linear_interpolator.sv -----
// ---------------------------------------------------------------------------
// tb_table_linear_interpolator
// Self-checking bench: breakpoint writes and queries on the stream port, the
// table size on the APB port; every rate beat is checked against a local
// interpolation of the table held in the bench.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_table_linear_interpolator;
    import tli_pkg::*;

    localparam int StallLimit = 5000;
    localparam int SettleCycles = 200;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [31:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    table_linear_interpolator dut (.*);

    // bench copy of the block state
    bit [31:0] absc_tab [TableDepth];
    bit [31:0] val_tab [TableDepth];
    int unsigned n_entries = 1;

    t_result rate_q[$];
    int errors = 0;
    int beats_sent = 0;
    int rates_checked = 0;
    int clamps_seen = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    int idle_cycles = 0;

    initial forever #5 i_clk = ~i_clk;

    function automatic t_result interpolate(bit [31:0] q);
        int unsigned k;
        bit found;
        bit [31:0] lo_t, hi_t, lo_v, hi_v, dmag;
        bit [64:0] amag, bmag, p1, p2, num, quo;
        bit aneg, dneg, nneg;
        t_result r;
        r = '0;
        found = 1'b0;
        for (k = 1; k < n_entries; k++) begin
            if (absc_tab[k] > q) begin
                found = 1'b1;
                break;
            end
        end
        if (!found) begin
            r.rate = val_tab[n_entries - 1];
            r.beyond_last = 1'b1;
            return r;
        end
        lo_t = absc_tab[k - 1];
        hi_t = absc_tab[k];
        lo_v = val_tab[k - 1];
        hi_v = val_tab[k];
        r.below_first = (k == 1 && q < lo_t);
        if (hi_t == lo_t) begin
            r.rate = lo_v;
            return r;
        end
        aneg = q < lo_t;
        amag = aneg ? 65'(lo_t - q) : 65'(q - lo_t);
        bmag = 65'(32'(hi_t - q));
        dneg = hi_t < lo_t;
        dmag = dneg ? lo_t - hi_t : hi_t - lo_t;
        p1 = 65'(hi_v) * amag;
        p2 = 65'(lo_v) * bmag;
        nneg = 1'b0;
        if (!aneg) begin
            num = p1 + p2;
        end else if (p2 >= p1) begin
            num = p2 - p1;
        end else begin
            num = p1 - p2;
            nneg = 1'b1;
        end
        quo = num / 65'(dmag);
        if (quo == 0) begin
            r.rate = '0;
        end else if (nneg != dneg) begin
            r.rate = '0;
            r.clamped = 1'b1;
        end else if (quo > 65'h0_FFFF_FFFF) begin
            r.rate = '1;
            r.clamped = 1'b1;
        end else begin
            r.rate = quo[31:0];
        end
        return r;
    endfunction

    // one beat on the input stream; the bench state follows on acceptance
    task automatic send_beat(t_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, it.temp, it.val, it.absc, it.idx, it.mode};
        do @(posedge i_clk); while (!s_axis_tready);
        beats_sent++;
        if (it.mode == MODE_WRITE) begin
            absc_tab[it.idx] = it.absc;
            val_tab[it.idx] = it.val;
        end else begin
            rate_q.push_back(interpolate(it.temp));
        end
    endtask

    task automatic write_entry(int idx, bit [31:0] absc, bit [31:0] val);
        t_item it;
        it = '0;
        it.mode = MODE_WRITE;
        it.idx = 4'(idx);
        it.absc = absc;
        it.val = val;
        send_beat(it);
    endtask

    task automatic query(bit [31:0] temp);
        t_item it;
        it = '0;
        it.mode = MODE_QUERY;
        it.temp = temp;
        it.idx = 4'($urandom_range(15));
        it.absc = $urandom;
        it.val = $urandom;
        send_beat(it);
    endtask

    // stop offering, let every rate come back, then let queued writes settle
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (rate_q.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic set_entries(bit [31:0] v);
        int unsigned stored;
        drain();
        stored = v[4:0];
        if (stored < 1) stored = 1;
        if (stored > TableDepth) stored = TableDepth;
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(4 * REG_ENTRIES);
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[4:0] != 5'(stored)) begin
            $display("%0t table size readback: expected %0d got %0d", $time, stored,
                     prdata[4:0]);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        n_entries = stored;
        @(posedge i_clk);
    endtask

    // sorted table with a duplicate and an out-of-order pair, then edge queries
    task automatic test_directed_table;
        for (int k = 0; k < TableDepth; k++)
            write_entry(k, (k + 1) << 20, $urandom);
        write_entry(0, 32'h0010_0000, 32'h0001_0000);
        write_entry(1, 32'h0020_0000, 32'h0008_0000);
        write_entry(3, 32'h0030_0000, 32'h0000_0000);
        write_entry(6, 32'h0050_0000, 32'hFFFF_FFFF);
        set_entries(16);
        query(32'h0000_0000);
        query(32'h0010_0000);
        query(32'h0018_0000);
        query(32'h0030_0000);
        query(32'h0058_0000);
        query(32'h00A0_0001);
        query(32'hFFFF_FFFF);
        set_entries(17);
        query(32'h0200_0000);
    endtask

    // two-entry table: zero width, overflow, negative result, descending pair
    task automatic test_two_entry_cases;
        set_entries(2);
        write_entry(0, 32'h0005_0000, 32'h0000_1234);
        write_entry(1, 32'h0005_0000, 32'h0009_0000);
        query(32'h0000_1000);
        write_entry(0, 32'h1000_0000, 32'hFFFF_FFFF);
        write_entry(1, 32'h1000_0001, 32'h0000_0000);
        query(32'h0000_0000);
        query(32'h1000_0000);
        write_entry(0, 32'h0010_0000, 32'h0001_0000);
        write_entry(1, 32'h0020_0000, 32'h0008_0000);
        query(32'h0000_0000);
        write_entry(0, 32'h0030_0000, 32'h0004_0000);
        write_entry(1, 32'h0010_0000, 32'h0002_0000);
        query(32'h0000_0000);
        query(32'h0020_0000);
        query(32'hFFFF_FFFF);
        set_entries(0);
        query($urandom);
        set_entries(31);
    endtask

    task automatic random_item;
        int idx;
        bit [31:0] t;
        idx = $urandom_range(15);
        if ($urandom_range(99) < 25) begin
            case ($urandom_range(3))
                0: t = $urandom;
                1: t = absc_tab[(idx + 15) % TableDepth];
                default: t = (idx << 28) | $urandom_range(32'h0FFF_FFFF);
            endcase
            write_entry(idx, t, $urandom_range(3) == 0 ? $urandom : $urandom_range(32'hF_FFFF));
        end else begin
            case ($urandom_range(4))
                0: t = $urandom;
                1: t = absc_tab[idx];
                2: t = absc_tab[idx] - $urandom_range(1);
                default: t = absc_tab[idx] + $urandom_range(32'h00FF_FFFF) - 32'h0080_0000;
            endcase
            query(t);
        end
    endtask

    task automatic test_random_phase(int send_pct, int recv_pct, bit [31:0] size, int count);
        set_entries(size);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) random_item();
    endtask

    // long receiver hold while queries keep coming, so the input queue fills
    task automatic test_input_backpressure;
        set_entries(16);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end
            repeat (12) query(absc_tab[$urandom_range(15)] + $urandom_range(32'hFFFF));
        join
    endtask

    always @(posedge i_clk)
        m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (rate_q.size() == 0) begin
                $display("%0t unexpected rate beat: got %h tuser %b", $time, m_axis_tdata,
                         m_axis_tuser);
                errors++;
            end else begin
                want = rate_q.pop_front();
                rates_checked++;
                if (want.clamped) clamps_seen++;
                if (m_axis_tdata != want.rate) begin
                    $display("%0t rate: expected %h got %h", $time, want.rate, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser[0] != want.below_first) begin
                    $display("%0t below_first: expected %b got %b", $time, want.below_first,
                             m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tuser[1] != want.beyond_last) begin
                    $display("%0t beyond_last: expected %b got %b", $time, want.beyond_last,
                             m_axis_tuser[1]);
                    errors++;
                end
                if (m_axis_tuser[2] != want.clamped) begin
                    $display("%0t clamped: expected %b got %b", $time, want.clamped,
                             m_axis_tuser[2]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > StallLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_table();
        test_two_entry_cases();
        test_random_phase(0, 0, 16, 100);
        test_random_phase(67, 0, $urandom_range(2, 15), 100);
        test_random_phase(0, 67, 16, 100);
        test_random_phase(22, 22, $urandom_range(2, 16), 100);
        test_input_backpressure();
        drain();
        $display("Sent %0d input beats, checked %0d rate beats (%0d clamped)", beats_sent,
                 rates_checked, clamps_seen);
        $display("Covered table sizes 1, 2, 16 and random, with idle and stall phases");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
